// ===== sv/ptw_pkg.sv =====
// Shared types, codes and constants of the page table map and walk core.
// No dependencies; every other file but ptw_ram imports this package.
`default_nettype none
package ptw_pkg;

  localparam logic [1:0] REQ_MAP      = 2'd0;
  localparam logic [1:0] REQ_RESOLVE  = 2'd1;
  localparam logic [1:0] REQ_FINALIZE = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ALIGN    = 3'd1;
  localparam logic [2:0] ST_LOW      = 3'd2;
  localparam logic [2:0] ST_ZERO     = 3'd3;
  localparam logic [2:0] ST_WRAP     = 3'd4;
  localparam logic [2:0] ST_CONFLICT = 3'd5;
  localparam logic [2:0] ST_FULL     = 3'd6;
  localparam logic [2:0] ST_UNMAPPED = 3'd7;

  localparam logic [2:0] CFG_LEVELS = 3'd0;
  localparam logic [2:0] CFG_NX     = 3'd1;
  localparam logic [2:0] CFG_PAT    = 3'd2;
  localparam logic [2:0] CFG_GIG    = 3'd3;
  localparam logic [2:0] CFG_BASE   = 3'd4;

  localparam logic [63:0] E_PRESENT = 64'h1;
  localparam logic [63:0] E_WRITE   = 64'h2;
  localparam logic [63:0] E_ACC     = 64'h20;
  localparam logic [63:0] E_DIRTY   = 64'h40;
  localparam logic [63:0] E_BIG     = 64'h80;
  localparam logic [63:0] E_FB      = 64'h88;
  localparam logic [63:0] E_ADDR    = 64'hf_ffff_ffff_f000;
  localparam logic [63:0] E_NX      = 64'h8000_0000_0000_0000;
  localparam logic [63:0] E_BIT12   = 64'h1000;

  typedef enum logic [12:0] {
    S_CLR   = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_DISP  = 13'b0000000000100,
    S_MTOP  = 13'b0000000001000,
    S_MCUR  = 13'b0000000010000,
    S_MDEC  = 13'b0000000100000,
    S_MCLR  = 13'b0000001000000,
    S_MLINK = 13'b0000010000000,
    S_RRD   = 13'b0000100000000,
    S_RCHK  = 13'b0001000000000,
    S_FRD   = 13'b0010000000000,
    S_FWR   = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  typedef struct packed {
    logic       load_req;
    logic       map_start;
    logic       res_start;
    logic       fin_start;
    logic       st_we;
    logic [2:0] st_code;
    logic       addr_we;
    logic       rd_slot;
    logic       rd_fin;
    logic       wr_leaf;
    logic       wr_fin;
    logic       clr_write;
    logic       alloc;
    logic       link;
    logic       descend;
    logic       advance;
    logic       ascend;
    logic       rem_calc;
    logic       cur_calc;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] chk_code;
    logic       size_zero;
    logic       at_top;
    logic       lvl_zero;
    logic       is_direct;
    logic       slot_zero;
    logic       slot_big;
    logic       child_ok;
    logic       pool_full;
    logic       clr_last;
    logic       fin_last;
  } sts_t;

  function automatic logic [63:0] chunk_size(input logic [2:0] lvl);
    logic [63:0] c;
    case (lvl)
      3'd0: c = 64'h1000;
      3'd1: c = 64'h20_0000;
      3'd2: c = 64'h4000_0000;
      3'd3: c = 64'h80_0000_0000;
      default: c = 64'h1_0000_0000_0000;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== sv/ptw_ram.sv =====
// Table pool storage: one write port and one registered read port.
// Depends on nothing.
`default_nettype none
module ptw_ram #(
  parameter int AW    = 15,
  parameter int DEPTH = 32768
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [63:0]   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [63:0]   rdata
);

  logic [63:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/ptw_datapath.sv =====
// Datapath: configuration, request and walk registers, entry building and the pool.
// Depends on ptw_pkg and ptw_ram.
`default_nettype none
module ptw_datapath
  import ptw_pkg::*;
#(
  parameter int POOL_TABLES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic [1:0]  req_type,
  input  wire logic [63:0] virt_addr,
  input  wire logic [51:0] phys_addr,
  input  wire logic [63:0] map_size,
  input  wire logic [2:0]  page_flags,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  output logic [2:0]       status,
  output logic [51:0]      resolved_addr
);

  localparam int TBL_W = $clog2(POOL_TABLES);
  localparam int CNT_W = $clog2(POOL_TABLES + 1);
  localparam int AW    = TBL_W + 9;

  logic [2:0]  levels;
  logic        nx_ok;
  logic        pat_ok;
  logic        gig_ok;
  logic [19:0] base;

  logic [1:0]  rq_type;
  logic [63:0] virt;
  logic [51:0] phys;
  logic [63:0] rq_size;
  logic [2:0]  flags;

  logic [2:0]       lvl;
  logic [63:0]      lsize [5];
  logic [TBL_W-1:0] tbl [5];
  logic [CNT_W-1:0] used;
  logic [63:0]      rem;
  logic [63:0]      cur;
  logic [TBL_W-1:0] clr_tbl;
  logic [8:0]       cnt;
  logic [2:0]       res_status;
  logic [51:0]      res_addr;

  logic [63:0]      rdata;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [63:0]      ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;

  logic [2:0]       top_lvl;
  logic [2:0]       lvl_dn;
  logic [63:0]      csize;
  logic [63:0]      cmask;
  logic [8:0]       idx;
  logic [AW-1:0]    slot_addr;
  logic [63:0]      lsize_cur;
  logic [64:0]      wrap_sum;
  logic [2:0]       chk_code;
  logic [40:0]      child_diff;
  logic [TBL_W-1:0] child;
  logic [63:0]      leaf0;
  logic [63:0]      leaf;
  logic [39:0]      new_frame;
  logic [63:0]      tab_entry;
  logic [63:0]      addr_keep;
  logic [63:0]      walk_addr;

  assign top_lvl   = (levels == 3'd5) ? 3'd4 : 3'd3;
  assign lvl_dn    = lvl - 3'd1;
  assign csize     = chunk_size(lvl);
  assign cmask     = csize - 64'd1;
  assign lsize_cur = lsize[lvl];

  always_comb begin
    case (lvl)
      3'd0: idx = virt[20:12];
      3'd1: idx = virt[29:21];
      3'd2: idx = virt[38:30];
      3'd3: idx = virt[47:39];
      default: idx = virt[56:48];
    endcase
  end

  assign slot_addr = {tbl[lvl], idx};

  assign wrap_sum = {1'b0, virt} + {1'b0, rq_size - 64'd1};

  always_comb begin
    if ((virt[11:0] | phys[11:0] | rq_size[11:0]) != 12'd0) begin
      chk_code = ST_ALIGN;
    end else if ((levels == 3'd5) ? (virt[63:56] != 8'hff) : (virt[63:47] != 17'h1ffff)) begin
      chk_code = ST_LOW;
    end else if (rq_size == 64'd0) begin
      chk_code = ST_ZERO;
    end else if (wrap_sum[64]) begin
      chk_code = ST_WRAP;
    end else begin
      chk_code = ST_OK;
    end
  end

  assign sts.chk_code = chk_code;

  assign child_diff = {1'b0, rdata[51:12]} - {21'd0, base};
  assign child      = child_diff[TBL_W-1:0];

  assign sts.req_type  = rq_type;
  assign sts.size_zero = (lsize_cur == 64'd0);
  assign sts.at_top    = (lvl == top_lvl);
  assign sts.lvl_zero  = (lvl == 3'd0);
  assign sts.is_direct = ((lvl <= 3'd1) || ((lvl == 3'd2) && gig_ok)) && (cur == csize)
                         && (({12'd0, phys} & cmask) == 64'd0);
  assign sts.slot_zero = (rdata == 64'd0);
  assign sts.slot_big  = rdata[7];
  assign sts.child_ok  = !child_diff[40] && (child_diff[39:0] < 40'(used));
  assign sts.pool_full = (used >= CNT_W'(POOL_TABLES));
  assign sts.clr_last  = (cnt == 9'd511);
  assign sts.fin_last  = (cnt[7:0] == 8'd255);

  always_comb begin
    leaf0 = {12'd0, phys} | E_PRESENT | E_ACC | E_DIRTY;
    if (flags[0]) begin
      leaf0 = leaf0 | E_WRITE;
    end
    if (!flags[1]) begin
      leaf0 = leaf0 | E_NX;
    end
    if (flags[2]) begin
      leaf0 = leaf0 | E_FB;
    end
    if (lvl != 3'd0) begin
      leaf = leaf0 | (64'(leaf0[7]) << 12) | E_BIG;
    end else begin
      leaf = leaf0;
    end
  end

  assign new_frame = {20'd0, base} + 40'(clr_tbl);
  assign tab_entry = {12'd0, new_frame, 12'd0} | E_DIRTY | E_ACC | E_WRITE | E_PRESENT;

  assign addr_keep = (lvl == 3'd0) ? E_ADDR : (E_ADDR & ~E_BIT12);
  assign walk_addr = (rdata & addr_keep) | (virt & cmask);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_addr;
    ram_wdata = leaf;
    if (cmd.clr_write) begin
      ram_we    = 1'b1;
      ram_waddr = {clr_tbl, cnt};
      ram_wdata = 64'd0;
    end else if (cmd.wr_leaf) begin
      ram_we    = 1'b1;
    end else if (cmd.link) begin
      ram_we    = 1'b1;
      ram_wdata = tab_entry;
    end else if (cmd.wr_fin) begin
      ram_we    = 1'b1;
      ram_waddr = {TBL_W'(0), 1'b0, cnt[7:0]};
      ram_wdata = rdata;
    end
  end

  assign ram_re    = cmd.rd_slot | cmd.rd_fin;
  assign ram_raddr = cmd.rd_fin ? {TBL_W'(0), 1'b1, cnt[7:0]} : slot_addr;

  ptw_ram #(
    .AW    (AW),
    .DEPTH (POOL_TABLES * 512)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      levels  <= 3'd4;
      nx_ok   <= 1'b1;
      pat_ok  <= 1'b1;
      gig_ok  <= 1'b0;
      base    <= 20'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEVELS: levels <= cfg_data[2:0];
        CFG_NX:     nx_ok  <= cfg_data[0];
        CFG_PAT:    pat_ok <= cfg_data[0];
        CFG_GIG:    gig_ok <= cfg_data[0];
        CFG_BASE:   base   <= cfg_data[19:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= CNT_W'(1);
      cnt     <= 9'd0;
      clr_tbl <= '0;
      lvl     <= 3'd0;
    end else begin
      if (cmd.alloc) begin
        used    <= used + CNT_W'(1);
        clr_tbl <= used[TBL_W-1:0];
        cnt     <= 9'd0;
      end else if (cmd.fin_start) begin
        cnt <= 9'd0;
      end else if (cmd.clr_write || cmd.wr_fin) begin
        cnt <= cnt + 9'd1;
      end
      if (cmd.map_start || cmd.res_start) begin
        lvl <= top_lvl;
      end else if (cmd.descend || cmd.link) begin
        lvl <= lvl_dn;
      end else if (cmd.ascend) begin
        lvl <= lvl + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      rq_type    <= req_type;
      virt       <= virt_addr;
      phys       <= phys_addr;
      rq_size    <= map_size;
      flags      <= {page_flags[2] & pat_ok, page_flags[1] | !nx_ok, page_flags[0]};
      res_status <= ST_OK;
      res_addr   <= 52'd0;
    end
    if (cmd.map_start) begin
      lsize[top_lvl] <= rq_size;
      tbl[top_lvl]   <= '0;
    end
    if (cmd.res_start) begin
      tbl[top_lvl] <= '0;
    end
    if (cmd.rem_calc) begin
      rem <= csize - (virt & cmask);
    end
    if (cmd.cur_calc) begin
      cur <= (rem < lsize_cur) ? rem : lsize_cur;
    end
    if (cmd.advance) begin
      virt       <= virt + cur;
      phys       <= phys + cur[51:0];
      lsize[lvl] <= lsize_cur - cur;
    end
    if (cmd.descend || cmd.link) begin
      lsize[lvl]    <= lsize_cur - cur;
      lsize[lvl_dn] <= cur;
      tbl[lvl_dn]   <= cmd.link ? clr_tbl : child;
    end
    if (cmd.st_we) begin
      res_status <= cmd.st_code;
    end
    if (cmd.addr_we) begin
      res_addr <= walk_addr[51:0];
    end
    if (cmd.out_load) begin
      status        <= res_status;
      resolved_addr <= res_addr;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ptw_ctrl.sv =====
// Controller state machine sequencing map, resolve, finalize and table clearing.
// Depends on ptw_pkg.
`default_nettype none
module ptw_ctrl
  import ptw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.req_type)
          REQ_MAP: begin
            if (sts.chk_code != ST_OK) begin
              cmd.st_we   = 1'b1;
              cmd.st_code = sts.chk_code;
              state_next  = S_DONE;
            end else begin
              cmd.map_start = 1'b1;
              state_next    = S_MTOP;
            end
          end
          REQ_RESOLVE: begin
            cmd.res_start = 1'b1;
            state_next    = S_RRD;
          end
          REQ_FINALIZE: begin
            cmd.fin_start = 1'b1;
            state_next    = S_FRD;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_MTOP: begin
        if (sts.size_zero) begin
          if (sts.at_top) begin
            cmd.st_we   = 1'b1;
            cmd.st_code = ST_OK;
            state_next  = S_DONE;
          end else begin
            cmd.ascend = 1'b1;
          end
        end else begin
          cmd.rem_calc = 1'b1;
          state_next   = S_MCUR;
        end
      end
      S_MCUR: begin
        cmd.cur_calc = 1'b1;
        cmd.rd_slot  = 1'b1;
        state_next   = S_MDEC;
      end
      S_MDEC: begin
        state_next = S_DONE;
        cmd.st_we  = 1'b1;
        if (sts.is_direct) begin
          if (sts.slot_zero) begin
            cmd.st_we   = 1'b0;
            cmd.wr_leaf = 1'b1;
            cmd.advance = 1'b1;
            state_next  = S_MTOP;
          end else begin
            cmd.st_code = ST_CONFLICT;
          end
        end else if (sts.lvl_zero) begin
          cmd.st_code = ST_CONFLICT;
        end else if (sts.slot_zero) begin
          if (sts.pool_full) begin
            cmd.st_code = ST_FULL;
          end else begin
            cmd.st_we  = 1'b0;
            cmd.alloc  = 1'b1;
            state_next = S_MCLR;
          end
        end else if (sts.slot_big || !sts.child_ok) begin
          cmd.st_code = ST_CONFLICT;
        end else begin
          cmd.st_we   = 1'b0;
          cmd.descend = 1'b1;
          state_next  = S_MTOP;
        end
      end
      S_MCLR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) begin
          state_next = S_MLINK;
        end
      end
      S_MLINK: begin
        cmd.link   = 1'b1;
        state_next = S_MTOP;
      end
      S_RRD: begin
        cmd.rd_slot = 1'b1;
        state_next  = S_RCHK;
      end
      S_RCHK: begin
        state_next = S_DONE;
        cmd.st_we  = 1'b1;
        if (sts.slot_zero) begin
          cmd.st_code = ST_UNMAPPED;
        end else if (sts.lvl_zero || sts.slot_big) begin
          cmd.st_code = ST_OK;
          cmd.addr_we = 1'b1;
        end else if (!sts.child_ok) begin
          cmd.st_code = ST_UNMAPPED;
        end else begin
          cmd.st_we   = 1'b0;
          cmd.descend = 1'b1;
          state_next  = S_RRD;
        end
      end
      S_FRD: begin
        cmd.rd_fin = 1'b1;
        state_next = S_FWR;
      end
      S_FWR: begin
        cmd.wr_fin = 1'b1;
        state_next = sts.fin_last ? S_DONE : S_FRD;
      end
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/page_table_map_and_walk_core.sv =====
// Top level of the page table map and walk core.
// Depends on ptw_pkg, ptw_ctrl and ptw_datapath.
//
// Builds and walks x86-64 four- or five-level page tables in an on-chip pool of
// POOL_TABLES tables of 512 entries, one item at a time, one result per item.
// After reset the top table is cleared, and no item is taken until that is done.
// Every item is loaded and dispatched first; its result is handed off once the
// output register is free. A map visits each entry at each level in S_MTOP,
// S_MCUR and S_MDEC, returns to a level above in S_MTOP and finishes there; each
// new table is allocated, cleared one entry per cycle through the single pool
// write port, then linked. A resolve reads (S_RRD) and checks (S_RCHK) one entry
// per level via the registered pool read. A finalize copies 256 entries, one
// read and one write per copied entry. Configuration writes are always ready.
`default_nettype none
module page_table_map_and_walk_core
  import ptw_pkg::*;
#(
  parameter int POOL_TABLES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [63:0] virt_addr,
  input  wire logic [51:0] phys_addr,
  input  wire logic [63:0] map_size,
  input  wire logic [2:0]  page_flags,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic [2:0]       status,
  output logic [51:0]      resolved_addr
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  ptw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ptw_datapath #(
    .POOL_TABLES (POOL_TABLES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_valid & cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req_type      (req_type),
    .virt_addr     (virt_addr),
    .phys_addr     (phys_addr),
    .map_size      (map_size),
    .page_flags    (page_flags),
    .cmd           (cmd),
    .sts           (sts),
    .status        (status),
    .resolved_addr (resolved_addr)
  );

endmodule
`default_nettype wire
